/* hdl/slcd_pkg.sv */
// slcd_pkg: shared types and constants of the serial lcd write engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  // stream widths, whole bytes
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // serial byte patterns
  localparam logic [7:0] POLL_BYTE = 8'hfc;
  localparam logic [7:0] SYNC_CMD  = 8'hf8;
  localparam logic [7:0] SYNC_DATA = 8'hfa;
  localparam logic [7:0] HI_MASK   = 8'hf0;
  localparam logic [7:0] LO_MASK   = 8'h0f;
  localparam int unsigned BUSY_POS = 7;

  // bits per transmitted byte and per status read
  localparam logic [4:0] TX_BITS = 5'd8;
  localparam logic [4:0] RX_BITS = 5'd16;
  localparam logic [4:0] LAST_TX_BIT = 5'd7;

  // one tick offered on the input side
  typedef struct packed {
    logic       req_valid;
    logic       func;
    logic [7:0] req_byte;
    logic       sid_in;
  } req_t;

  // one tick of pin levels and status on the output side
  typedef struct packed {
    logic       sclk_level;
    logic       sid_level;
    logic       chip_select;
    logic       ready_res;
    logic       done_res;
    logic [7:0] status_byte;
  } res_t;

endpackage

`default_nettype wire

/* hdl/serial_lcd_write_engine.sv */
// serial_lcd_write_engine: top level of the three-wire lcd write engine
// depends on slcd_pkg, slcd_seq and slcd_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one tick of a three-wire serial lcd bus sequencer and
// yields exactly one output beat with the pin levels for that tick (serial
// clock, serial data, chip select), an idle flag, a done pulse and the last
// status read. The levels on a beat reflect the sequencer state before the
// tick is applied. An idle engine takes a request when req_valid is set and
// raises chip select from the next beat. It then polls the busy flag: it
// sends 0xfc and clocks in sixteen status bits, sid_in being sampled on
// high-clock ticks, and repeats the poll while bit 7 of the first status byte
// is set. It then sends the sync byte (0xf8, or 0xfa for display data), the
// high nibble and the low nibble of the byte, and returns to idle. Every
// serial bit takes two beats, clock low then clock high. Rate: one beat per
// clock while no result waits downstream, the output beat being registered; the
// sequencer state is updated in the same cycle a beat is taken, and with the
// one result register the next beat enters in the cycle the held result
// leaves, so a result waiting downstream holds off the input.

module serial_lcd_write_engine
  import slcd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream, one tick per beat
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // req_valid, req_byte[7:0], sid_in, zeros
  input  wire logic                   s_axis_tuser,  // func
  // output stream, one result per tick
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // sclk_level, sid_level, chip_select,
                                                     // ready_res, done_res,
                                                     // status_byte[7:0], zeros
);

  req_t req;
  res_t seq_res;
  res_t out_res;
  logic tick;
  logic space;

  // unpack the input beat
  assign req.req_valid = s_axis_tdata[0];
  assign req.req_byte  = s_axis_tdata[8:1];
  assign req.sid_in    = s_axis_tdata[9];
  assign req.func      = s_axis_tuser;

  assign s_axis_tready = space;
  assign tick          = s_axis_tvalid && space;

  slcd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .req_i  (req),
    .res_o  (seq_res)
  );

  slcd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (tick),
    .res_i   (seq_res),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // pack the output beat, lowest field first
  assign m_axis_tdata = {3'b000,
                         out_res.status_byte,
                         out_res.done_res,
                         out_res.ready_res,
                         out_res.chip_select,
                         out_res.sid_level,
                         out_res.sclk_level};

endmodule

`default_nettype wire

/* hdl/slcd_seq.sv */
// slcd_seq: bit sequencer state and the per-tick result logic
// depends on slcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slcd_seq
  import slcd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tick_i,  // beat accepted this cycle
  input  wire req_t req_i,
  output res_t      res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POLL_TX,
    ST_POLL_RX,
    ST_SYNC_TX,
    ST_HI_TX,
    ST_LO_TX
  } stage_e;

  stage_e      stage_q, stage_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        phase_q, phase_d;
  logic [7:0]  tx_q, tx_d;
  logic [15:0] rx_q, rx_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_func_q, held_func_d;
  logic [7:0]  status_q, status_d;

  logic        busy;
  logic        sending;
  logic [4:0]  cnt_inc;

  always_comb begin
    busy    = (stage_q != ST_IDLE);
    sending = (stage_q == ST_POLL_TX) || (stage_q == ST_SYNC_TX) ||
              (stage_q == ST_HI_TX) || (stage_q == ST_LO_TX);
    cnt_inc = cnt_q + 5'd1;

    // outputs reflect the state at the start of the tick
    res_o.sclk_level  = busy && phase_q;
    res_o.sid_level   = sending && tx_q[7];
    res_o.chip_select = busy;
    res_o.ready_res   = !busy;
    res_o.done_res    = (stage_q == ST_LO_TX) && phase_q && (cnt_q == LAST_TX_BIT);
    res_o.status_byte = status_q;

    stage_d     = stage_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    tx_d        = tx_q;
    rx_d        = rx_q;
    held_byte_d = held_byte_q;
    held_func_d = held_func_q;
    status_d    = status_q;

    if (!busy) begin
      if (req_i.req_valid) begin
        held_byte_d = req_i.req_byte;
        held_func_d = req_i.func;
        tx_d        = POLL_BYTE;
        cnt_d       = '0;
        phase_d     = 1'b0;
        stage_d     = ST_POLL_TX;
      end
    end else if (!phase_q) begin
      phase_d = 1'b1;
    end else if (sending) begin
      phase_d = 1'b0;
      tx_d    = {tx_q[6:0], 1'b0};
      cnt_d   = cnt_inc;
      if (cnt_inc >= TX_BITS) begin
        cnt_d = '0;
        case (stage_q)
          ST_POLL_TX: begin
            rx_d    = '0;
            stage_d = ST_POLL_RX;
          end
          ST_SYNC_TX: begin
            tx_d    = held_byte_q & HI_MASK;
            stage_d = ST_HI_TX;
          end
          ST_HI_TX: begin
            tx_d    = {held_byte_q[3:0], 4'b0000};
            stage_d = ST_LO_TX;
          end
          default: begin
            stage_d = ST_IDLE;
          end
        endcase
      end
    end else begin
      // receive: sample the data line on the high tick
      phase_d = 1'b0;
      rx_d    = {rx_q[14:0], req_i.sid_in};
      cnt_d   = cnt_inc;
      if (cnt_inc >= RX_BITS) begin
        cnt_d    = '0;
        status_d = (rx_d[15:8] & HI_MASK) | (rx_d[7:0] & LO_MASK);
        if (rx_d[8 + BUSY_POS]) begin
          tx_d    = POLL_BYTE;
          stage_d = ST_POLL_TX;
        end else begin
          tx_d    = held_func_q ? SYNC_DATA : SYNC_CMD;
          stage_d = ST_SYNC_TX;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_IDLE;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      tx_q        <= '0;
      rx_q        <= '0;
      held_byte_q <= '0;
      held_func_q <= 1'b0;
      status_q    <= '0;
    end else if (tick_i) begin
      stage_q     <= stage_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      held_byte_q <= held_byte_d;
      held_func_q <= held_func_d;
      status_q    <= status_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/slcd_out_reg.sv */
// slcd_out_reg: result register between the sequencer and the output stream
// depends on slcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slcd_out_reg
  import slcd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,   // new result this cycle
  input  wire res_t res_i,
  output logic      space_o,  // a result can be loaded this cycle
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      res_o
);

  logic valid_q;
  res_t res_q;

  // room when empty or when the held beat leaves this cycle
  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/slcd_checker.sv */
// slcd_checker: port-level checks for serial_lcd_write_engine, with its bind
// depends on slcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slcd_checker
  import slcd_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_tvalid_i,
  input wire logic                   s_tready_i,
  input wire logic                   m_tvalid_i,
  input wire logic                   m_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_tdata_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled result beat changed");

  // the input side is never blocked while no result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("input stalled with empty result register");

  // an accepted tick shows up as a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> m_tvalid_i)
    else $error("accepted tick produced no result");

  // idle flag and chip select are complementary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[2] != m_tdata_i[3]))
    else $error("chip select and idle flag disagree");

  // done only on a high-clock tick inside a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[4] |-> m_tdata_i[0] && m_tdata_i[2])
    else $error("done outside a high-clock transfer tick");

endmodule

bind serial_lcd_write_engine slcd_checker u_slcd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

`default_nettype wire
